/* src/frt_pkg.sv */
// Package for the fragment reassembly tracker: types, constants and status codes.
package frt_pkg;

   localparam int PendingEntries = 16;
   localparam int SavedEntries = 16;
   localparam int PendIdxW = (PendingEntries > 1) ? $clog2(PendingEntries) : 1;
   localparam int SaveIdxW = (SavedEntries > 1) ? $clog2(SavedEntries) : 1;
   localparam logic [5:0] FRAG_MASK = 6'h3F;
   localparam logic [15:0] LEN_MAX = 16'hFFFF;
   localparam logic [15:0] MAX_SIZE_RESET = 16'd32768;

   typedef enum logic [3:0] {
      ST_WHOLE     = 4'd0,
      ST_STARTED   = 4'd1,
      ST_APPENDED  = 4'd2,
      ST_COMPLETED = 4'd3,
      ST_SAVED     = 4'd4,
      ST_IGNORED   = 4'd5,
      ST_TOO_LONG  = 4'd6,
      ST_DUPLICATE = 4'd7,
      ST_NO_ID     = 4'd8,
      ST_FULL      = 4'd9
   } status_type;

   typedef struct packed {
      logic [31:0] message_id;
      logic        is_follow_on;
      logic [5:0]  fragment_number;
      logic        is_final;
      logic [9:0]  fragment_size;
      logic [7:0]  fragment_tag;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [31:0] result_message_id;
      logic [15:0] assembled_length;
      logic        message_done;
      logic        merged_saved;
      logic [7:0]  merged_tag;
      logic [7:0]  first_tag;
   } rsp_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_LOOKUP,
      FSM_UPDATE
   } fsm_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic update;
   } cmd_type;

   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? LEN_MAX : s[15:0];
   endfunction

endpackage

/* src/frt_ctrl.sv */
// Controller state machine of the fragment reassembly tracker.
module frt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output frt_pkg::cmd_type  cmd
);
   import frt_pkg::*;

   fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            cmd.capture = start;
            if (start) begin
               state_in = FSM_LOOKUP;
            end
         end
         FSM_LOOKUP: begin
            busy = 1'b1;
            state_in = FSM_UPDATE;
         end
         FSM_UPDATE: begin
            busy = 1'b1;
            cmd.update = 1'b1;
            state_in = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_update_after_lookup: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> $past(state_ff) == FSM_LOOKUP)
      else $error("update without lookup");
   a_capture_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == FSM_LOOKUP)
      else $error("capture did not start lookup");
   a_busy_two: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> busy ##1 busy)
      else $error("busy window wrong");
`endif

endmodule

/* src/frt_datapath.sv */
// Datapath of the fragment reassembly tracker: tables, lookup and update.
module frt_datapath (
   input  logic              clock,
   input  logic              reset,
   input  frt_pkg::cmd_type  cmd,
   input  frt_pkg::req_type  req_word,
   input  logic              csr_write,
   input  logic [15:0]       csr_data,
   output logic              rsp_valid,
   output frt_pkg::rsp_type  rsp_word
);
   import frt_pkg::*;

   // Pending table.
   logic [PendingEntries-1:0] pv_ff, pv_in;
   logic [31:0] pid_ff [PendingEntries];
   logic [5:0]  pnext_ff [PendingEntries];
   logic [15:0] plen_ff [PendingEntries];
   logic [7:0]  ptag_ff [PendingEntries];
   // Saved table.
   logic [SavedEntries-1:0] sv_ff, sv_in;
   logic [31:0] sid_ff [SavedEntries];
   logic [5:0]  snum_ff [SavedEntries];
   logic        slast_ff [SavedEntries];
   logic [9:0]  ssize_ff [SavedEntries];
   logic [7:0]  stag_ff [SavedEntries];

   logic [15:0] max_ff;
   req_type     req_ff;

   // Lookup results registered for the update cycle.
   logic                p_hit_ff, s_hit_ff, p_free_ok_ff, s_free_ok_ff;
   logic [PendIdxW-1:0] p_idx_ff, p_free_ff;
   logic [SaveIdxW-1:0] s_idx_ff, s_free_ff;

   logic                p_hit_c, s_hit_c, p_free_ok_c, s_free_ok_c;
   logic [PendIdxW-1:0] p_idx_c, p_free_c;
   logic [SaveIdxW-1:0] s_idx_c, s_free_c;

   always_comb begin
      p_hit_c = 1'b0; p_idx_c = '0; p_free_ok_c = 1'b0; p_free_c = '0;
      for (int i = PendingEntries - 1; i >= 0; i--) begin
         if (pv_ff[i] && pid_ff[i] == req_ff.message_id) begin
            p_hit_c = 1'b1;
            p_idx_c = PendIdxW'(i);
         end
         if (!pv_ff[i]) begin
            p_free_ok_c = 1'b1;
            p_free_c = PendIdxW'(i);
         end
      end
      s_hit_c = 1'b0; s_idx_c = '0; s_free_ok_c = 1'b0; s_free_c = '0;
      for (int i = SavedEntries - 1; i >= 0; i--) begin
         if (sv_ff[i] && sid_ff[i] == req_ff.message_id) begin
            s_hit_c = 1'b1;
            s_idx_c = SaveIdxW'(i);
         end
         if (!sv_ff[i]) begin
            s_free_ok_c = 1'b1;
            s_free_c = SaveIdxW'(i);
         end
      end
   end

   // Update decision.
   rsp_type             r;
   logic                p_wr, p_clr, s_wr, s_clr;
   logic [PendIdxW-1:0] p_wi;
   logic [5:0]          nx_next;
   logic [15:0]         nx_len;
   logic [15:0]         base_len;
   logic [5:0]          base_next;
   logic [16:0]         total;
   logic                do_merge;

   always_comb begin
      r = '0;
      r.result_message_id = req_ff.message_id;
      p_wr = 1'b0; p_clr = 1'b0; s_wr = 1'b0; s_clr = 1'b0;
      p_wi = p_idx_ff;
      nx_next = pnext_ff[p_idx_ff];
      nx_len = plen_ff[p_idx_ff];
      base_len = '0; base_next = '0; do_merge = 1'b0;
      total = {1'b0, plen_ff[p_idx_ff]} + {7'd0, req_ff.fragment_size};
      if (!req_ff.is_follow_on && req_ff.is_final) begin
         r.status = ST_WHOLE;
         r.assembled_length = {6'd0, req_ff.fragment_size};
         r.message_done = 1'b1;
         r.first_tag = req_ff.fragment_tag;
      end else if (req_ff.message_id == '0) begin
         r.status = ST_NO_ID;
      end else if (!req_ff.is_follow_on) begin
         if (p_hit_ff) begin
            r.status = ST_DUPLICATE;
            r.assembled_length = plen_ff[p_idx_ff];
            r.first_tag = ptag_ff[p_idx_ff];
         end else if (!p_free_ok_ff) begin
            r.status = ST_FULL;
         end else begin
            r.status = ST_STARTED;
            r.first_tag = req_ff.fragment_tag;
            p_wr = 1'b1;
            p_wi = p_free_ff;
            base_len = {6'd0, req_ff.fragment_size};
            base_next = 6'd1;
            do_merge = 1'b1;
         end
      end else if (p_hit_ff && pnext_ff[p_idx_ff] == req_ff.fragment_number) begin
         r.first_tag = ptag_ff[p_idx_ff];
         if (total < {1'b0, max_ff}) begin
            base_len = sat_add(plen_ff[p_idx_ff], {6'd0, req_ff.fragment_size});
            r.assembled_length = base_len;
            if (req_ff.is_final) begin
               r.status = ST_COMPLETED;
               r.message_done = 1'b1;
               p_clr = 1'b1;
            end else begin
               r.status = ST_APPENDED;
               p_wr = 1'b1;
               base_next = (pnext_ff[p_idx_ff] + 6'd1) & FRAG_MASK;
               do_merge = 1'b1;
            end
         end else begin
            r.status = ST_TOO_LONG;
            r.assembled_length = plen_ff[p_idx_ff];
            p_clr = 1'b1;
         end
      end else begin
         if (s_hit_ff) begin
            r.status = ST_IGNORED;
         end else if (s_free_ok_ff) begin
            r.status = ST_SAVED;
            s_wr = 1'b1;
         end else begin
            r.status = ST_FULL;
         end
         if (p_hit_ff) begin
            r.assembled_length = plen_ff[p_idx_ff];
            r.first_tag = ptag_ff[p_idx_ff];
         end
      end
      if (do_merge) begin
         nx_len = base_len;
         nx_next = base_next;
         r.assembled_length = base_len;
         if (s_hit_ff && snum_ff[s_idx_ff] == base_next) begin
            nx_len = sat_add(base_len, {6'd0, ssize_ff[s_idx_ff]});
            r.assembled_length = nx_len;
            r.merged_saved = 1'b1;
            r.merged_tag = stag_ff[s_idx_ff];
            s_clr = 1'b1;
            if (slast_ff[s_idx_ff]) begin
               r.message_done = 1'b1;
               p_wr = 1'b0;
               p_clr = 1'b1;
            end else begin
               nx_next = (base_next + 6'd1) & FRAG_MASK;
            end
         end
      end
   end

   always_comb begin
      pv_in = pv_ff;
      sv_in = sv_ff;
      if (cmd.update) begin
         if (p_wr) pv_in[p_wi] = 1'b1;
         if (p_clr) pv_in[p_wi] = 1'b0;
         if (s_wr) sv_in[s_free_ff] = 1'b1;
         if (s_clr) sv_in[s_idx_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
         sv_ff <= '0;
         max_ff <= MAX_SIZE_RESET;
         rsp_valid <= 1'b0;
      end else begin
         pv_ff <= pv_in;
         sv_ff <= sv_in;
         if (csr_write) max_ff <= csr_data;
         rsp_valid <= cmd.update;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_word;
      p_hit_ff <= p_hit_c;
      p_idx_ff <= p_idx_c;
      p_free_ok_ff <= p_free_ok_c;
      p_free_ff <= p_free_c;
      s_hit_ff <= s_hit_c;
      s_idx_ff <= s_idx_c;
      s_free_ok_ff <= s_free_ok_c;
      s_free_ff <= s_free_c;
      if (cmd.update) begin
         rsp_word <= r;
         if (p_wr) begin
            pid_ff[p_wi] <= req_ff.message_id;
            pnext_ff[p_wi] <= nx_next;
            plen_ff[p_wi] <= nx_len;
            if (!req_ff.is_follow_on) ptag_ff[p_wi] <= req_ff.fragment_tag;
         end
         if (s_wr) begin
            sid_ff[s_free_ff] <= req_ff.message_id;
            snum_ff[s_free_ff] <= req_ff.fragment_number;
            slast_ff[s_free_ff] <= req_ff.is_final;
            ssize_ff[s_free_ff] <= req_ff.fragment_size;
            stag_ff[s_free_ff] <= req_ff.fragment_tag;
         end
      end
   end

`ifndef SYNTHESIS
   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result held two cycles");
   a_done_frees: assert property (@(posedge clock) disable iff (reset)
      cmd.update && r.message_done && r.status != ST_WHOLE |=> !pv_ff[$past(p_wi)])
      else $error("done entry still valid");
   a_merge_frees: assert property (@(posedge clock) disable iff (reset)
      cmd.update && r.merged_saved |=> !sv_ff[$past(s_idx_ff)])
      else $error("merged entry still valid");
`endif

endmodule

/* src/fragment_reassembly_tracker_unit.sv */
// Top level of the fragment reassembly tracker.
//  channel   ports                      direction  handshake
//  request   start, busy, req_word      in         start && !busy
//  response  rsp_valid, rsp_word        out        rsp_valid, one cycle
//  config    csr_write, csr_data        in         csr_write
// Each word goes through capture, table lookup, then update, which sets rsp_valid
// in the next cycle; the lookup results over both tables are registered before
// the update. A new word is accepted the cycle after the update.
// Reset clears all valid bits and loads max_message_size with 32768.
// The receiver cannot stall; each result shows for exactly one cycle.
module fragment_reassembly_tracker_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  frt_pkg::req_type  req_word,
   input  logic              csr_write,
   input  logic [15:0]       csr_data,
   output logic              rsp_valid,
   output frt_pkg::rsp_type  rsp_word
);
   import frt_pkg::*;

   cmd_type cmd;

   frt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   frt_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_word  (req_word),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

/* dv/tb.sv */
// Testbench for the fragment reassembly tracker: directed table and cases, then random traffic.
`timescale 1ns / 100ps

module tb;
   import frt_pkg::*;

   localparam int NumRandom = 1220;
   localparam int WatchdogLimit = 20000;

   typedef struct {
      req_type    word;
      logic       has_exp;
      status_type st;
      logic [15:0] len;
   } row_type;

   typedef struct {
      logic        valid;
      logic [31:0] id;
      logic [5:0]  next;
      logic [15:0] len;
      logic [7:0]  ftag;
   } open_msg_type;

   typedef struct {
      logic        valid;
      logic [31:0] id;
      logic [5:0]  num;
      logic        last;
      logic [15:0] size;
      logic [7:0]  tag;
   } held_frag_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_word = '0;
   logic csr_write = 1'b0;
   logic [15:0] csr_data = '0;
   logic rsp_valid;
   rsp_type rsp_word;

   open_msg_type  open_msgs [PendingEntries];
   held_frag_type held_frags [SavedEntries];
   logic [15:0]   size_limit;
   rsp_type       expected_status_q [$];
   int mismatches = 0;
   int results_seen = 0;
   int idle_cycles = 0;
   int merges_seen = 0;
   int status_hits [10];

   fragment_reassembly_tracker_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .csr_write(csr_write), .csr_data(csr_data), .rsp_valid(rsp_valid), .rsp_word(rsp_word)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] len_add(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   task automatic clear_tables();
      foreach (open_msgs[i]) open_msgs[i].valid = 1'b0;
      foreach (held_frags[i]) held_frags[i].valid = 1'b0;
   endtask

   // Pulls in the held fragment of this message if it is the next one due.
   function automatic void absorb_held(int p, inout rsp_type r);
      for (int s = 0; s < SavedEntries; s++) begin
         if (held_frags[s].valid && held_frags[s].id == open_msgs[p].id) begin
            if (held_frags[s].num == open_msgs[p].next) begin
               open_msgs[p].len = len_add(open_msgs[p].len, held_frags[s].size);
               r.merged_saved = 1'b1;
               r.merged_tag = held_frags[s].tag;
               if (held_frags[s].last) begin
                  open_msgs[p].valid = 1'b0;
                  r.message_done = 1'b1;
               end else begin
                  open_msgs[p].next = open_msgs[p].next + 6'd1;
               end
               held_frags[s].valid = 1'b0;
            end
            return;
         end
      end
   endfunction

   function automatic rsp_type track_fragment(req_type q);
      rsp_type r;
      int p, f;
      logic [16:0] total;
      r = '0;
      r.result_message_id = q.message_id;
      p = -1;
      if (!q.is_follow_on && q.is_final) begin
         r.status = ST_WHOLE;
         r.assembled_length = 16'(q.fragment_size);
         r.message_done = 1'b1;
         r.first_tag = q.fragment_tag;
         return r;
      end
      if (q.message_id == 0) begin
         r.status = ST_NO_ID;
         return r;
      end
      for (int i = 0; i < PendingEntries; i++)
         if (p < 0 && open_msgs[i].valid && open_msgs[i].id == q.message_id) p = i;
      if (!q.is_follow_on) begin
         if (p >= 0) begin
            r.status = ST_DUPLICATE;
            r.assembled_length = open_msgs[p].len;
            r.first_tag = open_msgs[p].ftag;
            return r;
         end
         f = -1;
         for (int i = 0; i < PendingEntries; i++)
            if (f < 0 && !open_msgs[i].valid) f = i;
         if (f < 0) begin
            r.status = ST_FULL;
            return r;
         end
         open_msgs[f] = '{1'b1, q.message_id, 6'd1, 16'(q.fragment_size), q.fragment_tag};
         r.status = ST_STARTED;
         r.first_tag = q.fragment_tag;
         absorb_held(f, r);
         r.assembled_length = open_msgs[f].len;
         return r;
      end
      if (p >= 0 && open_msgs[p].next == q.fragment_number) begin
         total = {1'b0, open_msgs[p].len} + 17'(q.fragment_size);
         r.first_tag = open_msgs[p].ftag;
         if (total < {1'b0, size_limit}) begin
            open_msgs[p].len = len_add(open_msgs[p].len, 16'(q.fragment_size));
            if (q.is_final) begin
               open_msgs[p].valid = 1'b0;
               r.status = ST_COMPLETED;
               r.message_done = 1'b1;
            end else begin
               open_msgs[p].next = open_msgs[p].next + 6'd1;
               r.status = ST_APPENDED;
               absorb_held(p, r);
            end
            r.assembled_length = open_msgs[p].len;
         end else begin
            r.status = ST_TOO_LONG;
            r.assembled_length = open_msgs[p].len;
            open_msgs[p].valid = 1'b0;
         end
         return r;
      end
      r.status = ST_FULL;
      f = -1;
      for (int i = 0; i < SavedEntries; i++)
         if (held_frags[i].valid && held_frags[i].id == q.message_id) r.status = ST_IGNORED;
      if (r.status != ST_IGNORED) begin
         for (int i = 0; i < SavedEntries; i++)
            if (f < 0 && !held_frags[i].valid) f = i;
         if (f >= 0) begin
            held_frags[f] = '{1'b1, q.message_id, q.fragment_number, q.is_final,
                              16'(q.fragment_size), q.fragment_tag};
            r.status = ST_SAVED;
         end
      end
      if (p >= 0) begin
         r.assembled_length = open_msgs[p].len;
         r.first_tag = open_msgs[p].ftag;
      end
      return r;
   endfunction

   // Result checking at the rising edge.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_status_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected word: %p", rsp_word);
         end else begin
            e = expected_status_q.pop_front();
            if (rsp_word !== e) begin
               mismatches++;
               if (mismatches <= 10) $display("Mismatch: expected %p, got %p", e, rsp_word);
            end
            if (e.status <= ST_FULL) status_hits[e.status]++;
            if (e.merged_saved) merges_seen++;
         end
      end
   end

   // Watchdog on cycles without any accepted word or result.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("Watchdog expired");
         $display("FAILURE");
         $finish;
      end
   end

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      repeat (n) @(negedge clock);
   endtask

   // Drives one word and registers its expected result when it is taken.
   // The drive is done at the falling edge, so start may drop and rise again
   // in the same step when words follow each other.
   task automatic send_word(req_type q, logic gap);
      if (gap) idle_gap();
      req_word = q;
      start = 1'b1;
      do @(posedge clock); while (busy);
      expected_status_q.push_back(track_fragment(q));
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic drain();
      while (expected_status_q.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic set_limit(logic [15:0] v);
      drain();
      csr_data <= v;
      csr_write <= 1'b1;
      @(negedge clock);
      csr_write <= 1'b0;
      size_limit = v;
   endtask

   function automatic req_type make_frag(logic [31:0] id, logic fo, logic [5:0] num,
                                         logic fin, logic [9:0] sz, logic [7:0] tag);
      req_type q;
      q.message_id = id; q.is_follow_on = fo; q.fragment_number = num;
      q.is_final = fin; q.fragment_size = sz; q.fragment_tag = tag;
      return q;
   endfunction

   // Builds one message in random fragment order, with occasional noise.
   task automatic random_message(ref int sent);
      logic [31:0] id;
      int n, j;
      req_type frags [$];
      req_type t;
      id = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 24)) : $urandom;
      if ($urandom_range(0, 40) == 0) id = '0;
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 6);
      frags.push_back(make_frag(id, 1'b0, 6'($urandom), n == 1, 10'($urandom), 8'($urandom)));
      for (int k = 1; k < n; k++)
         frags.push_back(make_frag(id, 1'b1, 6'(k), k == n - 1,
                                   10'($urandom), 8'($urandom)));
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 4) == 0) begin
            j = $urandom_range(k, n - 1);
            t = frags[k]; frags[k] = frags[j]; frags[j] = t;
         end
      end
      foreach (frags[k]) begin
         if ($urandom_range(0, 12) == 0)
            t = make_frag($urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 24)) : id,
                          1'($urandom), 6'($urandom), 1'($urandom),
                          10'($urandom), 8'($urandom));
         else
            t = frags[k];
         send_word(t, 1'b1);
         sent++;
      end
   endtask

   initial begin
      row_type rows [$];
      int sent;
      clear_tables();
      size_limit = MAX_SIZE_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      rows = '{
         '{make_frag(32'hFFFF_FFFF, 1'b0, 6'h3F, 1'b1, 10'h3FF, 8'hFF), 1'b1, ST_WHOLE, 16'd1023},
         '{make_frag(32'h0, 1'b0, 6'h0, 1'b1, 10'h0, 8'h00), 1'b1, ST_WHOLE, 16'd0},
         '{make_frag(32'h0, 1'b1, 6'h3, 1'b0, 10'h3FF, 8'hFF), 1'b1, ST_NO_ID, 16'd0},
         '{make_frag(32'h0, 1'b0, 6'h0, 1'b0, 10'h5, 8'h1), 1'b1, ST_NO_ID, 16'd0},
         '{make_frag(32'h1, 1'b0, 6'h0, 1'b0, 10'd100, 8'hA1), 1'b1, ST_STARTED, 16'd100},
         '{make_frag(32'h1, 1'b0, 6'h0, 1'b0, 10'd7, 8'hA2), 1'b1, ST_DUPLICATE, 16'd100},
         '{make_frag(32'h1, 1'b1, 6'd2, 1'b0, 10'd20, 8'hB2), 1'b0, ST_WHOLE, 16'd0},
         '{make_frag(32'h1, 1'b1, 6'd3, 1'b1, 10'd30, 8'hB3), 1'b0, ST_WHOLE, 16'd0},
         '{make_frag(32'h1, 1'b1, 6'd1, 1'b0, 10'd10, 8'hB1), 1'b0, ST_WHOLE, 16'd0},
         '{make_frag(32'h1, 1'b1, 6'd3, 1'b1, 10'd30, 8'hB3), 1'b0, ST_WHOLE, 16'd0},
         '{make_frag(32'h2, 1'b1, 6'd1, 1'b1, 10'd50, 8'hC1), 1'b0, ST_WHOLE, 16'd0},
         '{make_frag(32'h2, 1'b0, 6'd0, 1'b0, 10'd60, 8'hC0), 1'b0, ST_WHOLE, 16'd0},
         '{make_frag(32'h3, 1'b0, 6'd0, 1'b0, 10'h3FF, 8'hD0), 1'b0, ST_WHOLE, 16'd0},
         '{make_frag(32'h3, 1'b1, 6'd1, 1'b1, 10'h3FF, 8'hD1), 1'b0, ST_WHOLE, 16'd0}
      };
      foreach (rows[k]) begin
         send_word(rows[k].word, 1'b0);
         if (rows[k].has_exp && (expected_status_q[$].status != rows[k].st ||
             expected_status_q[$].assembled_length != rows[k].len)) begin
            mismatches++;
            $display("Predictor disagrees with table row %0d", k);
         end
      end

      // Too long with a limit of 1, then a long message that runs into the length limit.
      set_limit(16'd1);
      send_word(make_frag(32'h4, 1'b0, 6'd0, 1'b0, 10'd0, 8'hE0), 1'b0);
      send_word(make_frag(32'h4, 1'b1, 6'd1, 1'b0, 10'd0, 8'hE1), 1'b0);
      send_word(make_frag(32'h5, 1'b0, 6'd0, 1'b0, 10'd0, 8'hE2), 1'b0);
      send_word(make_frag(32'h5, 1'b1, 6'd1, 1'b0, 10'd1, 8'hE3), 1'b0);
      set_limit(16'hFFFF);
      send_word(make_frag(32'h6, 1'b0, 6'd0, 1'b0, 10'h3FF, 8'h60), 1'b0);
      for (int k = 1; k <= 70; k++)
         send_word(make_frag(32'h6, 1'b1, 6'(k), 1'b0, 10'h3FF, 8'(k)), 1'b0);
      // Fill both tables to reach the full cases.
      for (int k = 0; k < PendingEntries + 1; k++)
         send_word(make_frag(32'h100 + k, 1'b0, 6'd0, 1'b0, 10'd1, 8'(k)), 1'b0);
      for (int k = 0; k < SavedEntries + 1; k++)
         send_word(make_frag(32'h200 + k, 1'b1, 6'd5, 1'b0, 10'd1, 8'(k)), 1'b0);

      // Random traffic; no reset is applied, so entries leave the tables only through the words sent.
      sent = 0;
      while (sent < NumRandom) begin
         if (sent > 0 && $urandom_range(0, 60) == 0) begin
            case ($urandom_range(0, 3))
               0: set_limit(16'd1);
               1: set_limit(16'hFFFF);
               2: set_limit(MAX_SIZE_RESET);
               default: set_limit(16'($urandom_range(200, 6000)));
            endcase
         end
         if ($urandom_range(0, 80) == 0) drain();
         random_message(sent);
         // Keep the tables from staying full: complete or drop stale entries.
         foreach (open_msgs[i]) begin
            if (open_msgs[i].valid && $urandom_range(0, 3) == 0) begin
               send_word(make_frag(open_msgs[i].id, 1'b1, open_msgs[i].next, 1'b1,
                                   10'($urandom), 8'($urandom)), 1'b1);
               sent++;
            end
         end
         // A start for a held fragment's message lets it merge or be appended later.
         foreach (held_frags[i]) begin
            if (held_frags[i].valid && !held_frags[i].last && $urandom_range(0, 3) == 0) begin
               send_word(make_frag(held_frags[i].id, 1'b0, 6'd0, 1'b0,
                                   10'($urandom), 8'($urandom)), 1'b1);
               sent++;
            end
         end
      end

      drain();
      $display("Run covered %0d results, %0d merges; status counts %p.",
               results_seen, merges_seen, status_hits);
      if (mismatches == 0 && expected_status_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d words outstanding", mismatches,
                  expected_status_q.size());
         $display("FAILURE");
      end
      $finish;
   end
endmodule
